// ===== rtl/rrss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin scheduler package
// Sizes, request codes, status codes and the microcode table of the
// scheduler sequencer.
// ----------------------------------------------------------------------------
package rrss_pkg;

   localparam int NUM_THREADS = 3;
   localparam int NUM_SEMS    = 8;

   localparam int TH_W   = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
   localparam int SEM_AW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;

   // Fixed field widths of the request and result channels.
   localparam int FUNC_W   = 2;
   localparam int SEM_ID_W = 3;
   localparam int COUNT_W  = 8;
   localparam int THREAD_W = 2;
   localparam int STATUS_W = 2;

   localparam logic [FUNC_W-1:0] FN_TICK   = 2'd0;
   localparam logic [FUNC_W-1:0] FN_WAIT   = 2'd1;
   localparam logic [FUNC_W-1:0] FN_SIGNAL = 2'd2;
   localparam logic [FUNC_W-1:0] FN_INIT   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ALL_BLOCKED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_WAITER   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_SATURATED   = 2'd3;

   typedef logic [2:0] step_type;
   typedef logic [2:0] act_type;
   typedef logic [2:0] cond_type;

   // Program addresses.
   localparam step_type STEP_IDLE   = 3'd0;
   localparam step_type STEP_FETCH  = 3'd1;
   localparam step_type STEP_INIT   = 3'd2;
   localparam step_type STEP_SIGNAL = 3'd3;
   localparam step_type STEP_WAKE   = 3'd4;
   localparam step_type STEP_WAIT   = 3'd5;
   localparam step_type STEP_RUN    = 3'd6;
   localparam step_type STEP_FINISH = 3'd7;

   // Datapath actions.
   localparam act_type ACT_NONE   = 3'd0;
   localparam act_type ACT_LOAD   = 3'd1;
   localparam act_type ACT_INIT   = 3'd2;
   localparam act_type ACT_SIGNAL = 3'd3;
   localparam act_type ACT_WAKE   = 3'd4;
   localparam act_type ACT_WAIT   = 3'd5;
   localparam act_type ACT_RUN    = 3'd6;
   localparam act_type ACT_EMIT   = 3'd7;

   // Sequencing conditions.
   localparam cond_type CND_START     = 3'd0;  // advance on start, else hold
   localparam cond_type CND_FUNC      = 3'd1;  // dispatch on the request code
   localparam cond_type CND_ALWAYS    = 3'd2;  // jump to target
   localparam cond_type CND_DONE_NEXT = 3'd3;  // target when done, else next step
   localparam cond_type CND_DONE_STAY = 3'd4;  // target when done, else repeat

   typedef struct packed {
      act_type  act;
      cond_type cond;
      step_type target;
   } ucode_type;

   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type word;
      word = '{act: ACT_NONE, cond: CND_START, target: STEP_IDLE};
      unique case (step)
         STEP_IDLE:   word = '{act: ACT_NONE,   cond: CND_START,     target: STEP_IDLE};
         STEP_FETCH:  word = '{act: ACT_LOAD,   cond: CND_FUNC,      target: STEP_FINISH};
         STEP_INIT:   word = '{act: ACT_INIT,   cond: CND_ALWAYS,    target: STEP_FINISH};
         STEP_SIGNAL: word = '{act: ACT_SIGNAL, cond: CND_DONE_NEXT, target: STEP_FINISH};
         STEP_WAKE:   word = '{act: ACT_WAKE,   cond: CND_DONE_STAY, target: STEP_FINISH};
         STEP_WAIT:   word = '{act: ACT_WAIT,   cond: CND_DONE_NEXT, target: STEP_FINISH};
         STEP_RUN:    word = '{act: ACT_RUN,    cond: CND_DONE_STAY, target: STEP_FINISH};
         STEP_FINISH: word = '{act: ACT_EMIT,   cond: CND_ALWAYS,    target: STEP_IDLE};
         default:     word = '{act: ACT_NONE,   cond: CND_START,     target: STEP_IDLE};
      endcase
      return word;
   endfunction

   // Next thread in round-robin order.
   function automatic logic [TH_W-1:0] thread_inc(input logic [TH_W-1:0] t);
      logic [TH_W-1:0] r;
      if (t == TH_W'(NUM_THREADS - 1)) begin
         r = '0;
      end else begin
         r = t + TH_W'(1);
      end
      return r;
   endfunction

endpackage

// ===== rtl/round_robin_scheduler_semaphores.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin thread scheduler with counting blocking semaphores
// A microcoded sequencer steps through each request: fetch, a count update
// and/or a one-thread-per-cycle round-robin scan as needed, and result emission.
// ----------------------------------------------------------------------------
// The next request is taken in the strobe cycle at the earliest; none is taken
// while a request is in flight. The thread scan loop checks one thread per step.
// The result shows for one cycle and cannot be held off. Synchronous reset clears
// all counts, all blocking records and sets thread 0 running.
module round_robin_scheduler_semaphores (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [rrss_pkg::FUNC_W-1:0]          req_func,
   input  logic [rrss_pkg::SEM_ID_W-1:0]        req_sem_id,
   input  logic signed [rrss_pkg::COUNT_W-1:0]  req_init_value,
   output logic                                 rsp_strobe,
   output logic [rrss_pkg::THREAD_W-1:0]        rsp_running_thread,
   output logic                                 rsp_caller_blocked,
   output logic                                 rsp_woken_valid,
   output logic [rrss_pkg::THREAD_W-1:0]        rsp_woken_thread,
   output logic signed [rrss_pkg::COUNT_W-1:0]  rsp_count_after,
   output logic [rrss_pkg::STATUS_W-1:0]        rsp_status
);

   localparam int NT = rrss_pkg::NUM_THREADS;
   localparam int NS = rrss_pkg::NUM_SEMS;
   localparam int TW = rrss_pkg::TH_W;
   localparam int CW = rrss_pkg::COUNT_W;
   localparam int SEM_AWX = rrss_pkg::SEM_AW;

   // Sequencer.
   rrss_pkg::step_type  pc_ff, pc_in;
   rrss_pkg::ucode_type uw;
   logic                done;

   // Request registers.
   logic [rrss_pkg::FUNC_W-1:0]   func_ff;
   logic [rrss_pkg::SEM_ID_W-1:0] sem_ff;
   logic signed [CW-1:0]          initv_ff;

   // Architectural state.
   logic signed [CW-1:0]          sem_count_ff [NS];
   logic                          blk_valid_ff [NT];
   logic [rrss_pkg::SEM_ID_W-1:0] blk_sem_ff   [NT];
   logic [TW-1:0]                 running_ff, running_in;

   // Working registers.
   logic signed [CW-1:0]          count_ff, count_in;
   logic [TW-1:0]                 cand_ff, cand_in;
   logic [TW-1:0]                 k_ff, k_in;
   logic [rrss_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                          cblk_ff, cblk_in;
   logic                          woken_ff, woken_in;
   logic [TW-1:0]                 wthread_ff, wthread_in;
   logic                          strobe_ff, strobe_in;

   // Datapath controls.
   logic                 sem_we;
   logic signed [CW-1:0] sem_wdata;
   logic                 blk_set;
   logic                 blk_clr;

   logic                 accept;
   logic                 in_range;
   logic [SEM_AWX-1:0]   sem_idx;
   logic signed [CW-1:0] dec_val;
   logic signed [CW-1:0] inc_val;
   logic                 sat_lo;
   logic                 sat_hi;
   logic                 last;
   logic                 cand_hit;
   logic                 cand_free;

   assign busy    = (pc_ff != rrss_pkg::STEP_IDLE);
   assign accept  = start && !busy;
   assign uw      = rrss_pkg::ucode_rom(pc_ff);

   assign in_range  = (int'(sem_ff) < NS);
   assign sem_idx   = SEM_AWX'(sem_ff);
   assign sat_lo    = (count_ff == {1'b1, {(CW-1){1'b0}}});
   assign sat_hi    = (count_ff == {1'b0, {(CW-1){1'b1}}});
   assign dec_val   = sat_lo ? count_ff : count_ff - CW'(1);
   assign inc_val   = sat_hi ? count_ff : count_ff + CW'(1);
   assign last      = (k_ff == TW'(NT - 1));
   assign cand_hit  = blk_valid_ff[cand_ff] && (blk_sem_ff[cand_ff] == sem_ff);
   assign cand_free = !blk_valid_ff[cand_ff];

   // Datapath driven by the current control word.
   always_comb begin
      count_in   = count_ff;
      cand_in    = cand_ff;
      k_in       = k_ff;
      status_in  = status_ff;
      cblk_in    = cblk_ff;
      woken_in   = woken_ff;
      wthread_in = wthread_ff;
      running_in = running_ff;
      strobe_in  = 1'b0;
      sem_we     = 1'b0;
      sem_wdata  = count_ff;
      blk_set    = 1'b0;
      blk_clr    = 1'b0;
      done       = 1'b0;
      unique case (uw.act)
         rrss_pkg::ACT_NONE: begin
         end
         rrss_pkg::ACT_LOAD: begin
            count_in   = (func_ff != rrss_pkg::FN_TICK && in_range) ?
                         sem_count_ff[sem_idx] : '0;
            cand_in    = rrss_pkg::thread_inc(running_ff);
            k_in       = '0;
            status_in  = rrss_pkg::ST_OK;
            cblk_in    = 1'b0;
            woken_in   = 1'b0;
            wthread_in = '0;
         end
         rrss_pkg::ACT_INIT: begin
            sem_we    = 1'b1;
            sem_wdata = initv_ff;
            count_in  = initv_ff;
         end
         rrss_pkg::ACT_SIGNAL: begin
            sem_we    = 1'b1;
            sem_wdata = inc_val;
            count_in  = inc_val;
            if (sat_hi) begin
               status_in = rrss_pkg::ST_SATURATED;
            end
            done = (inc_val > 0);
         end
         rrss_pkg::ACT_WAKE: begin
            done = cand_hit || last;
            if (cand_hit) begin
               blk_clr    = 1'b1;
               woken_in   = 1'b1;
               wthread_in = cand_ff;
            end else begin
               cand_in = rrss_pkg::thread_inc(cand_ff);
               k_in    = k_ff + TW'(1);
               if (last) begin
                  status_in = rrss_pkg::ST_NO_WAITER;
               end
            end
         end
         rrss_pkg::ACT_WAIT: begin
            sem_we    = 1'b1;
            sem_wdata = dec_val;
            count_in  = dec_val;
            if (sat_lo) begin
               status_in = rrss_pkg::ST_SATURATED;
            end
            done = (dec_val >= 0);
            if (dec_val < 0) begin
               blk_set = 1'b1;
               cblk_in = 1'b1;
            end
         end
         rrss_pkg::ACT_RUN: begin
            // The running thread comes last in the scan, so a thread that
            // just blocked itself is seen as blocked here.
            done = cand_free || last;
            if (cand_free) begin
               running_in = cand_ff;
            end else begin
               cand_in = rrss_pkg::thread_inc(cand_ff);
               k_in    = k_ff + TW'(1);
               if (last) begin
                  status_in = rrss_pkg::ST_ALL_BLOCKED;
               end
            end
         end
         rrss_pkg::ACT_EMIT: begin
            strobe_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Step counter with conditional jumps.
   always_comb begin
      pc_in = pc_ff;
      unique case (uw.cond)
         rrss_pkg::CND_START: begin
            pc_in = accept ? pc_ff + 3'd1 : pc_ff;
         end
         rrss_pkg::CND_FUNC: begin
            priority if (func_ff == rrss_pkg::FN_TICK) begin
               pc_in = rrss_pkg::STEP_RUN;
            end else if (!in_range) begin
               pc_in = uw.target;
            end else if (func_ff == rrss_pkg::FN_INIT) begin
               pc_in = rrss_pkg::STEP_INIT;
            end else if (func_ff == rrss_pkg::FN_WAIT) begin
               pc_in = rrss_pkg::STEP_WAIT;
            end else begin
               pc_in = rrss_pkg::STEP_SIGNAL;
            end
         end
         rrss_pkg::CND_ALWAYS: begin
            pc_in = uw.target;
         end
         rrss_pkg::CND_DONE_NEXT: begin
            pc_in = done ? uw.target : pc_ff + 3'd1;
         end
         rrss_pkg::CND_DONE_STAY: begin
            pc_in = done ? uw.target : pc_ff;
         end
         default: begin
            pc_in = rrss_pkg::STEP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff      <= rrss_pkg::STEP_IDLE;
         strobe_ff  <= 1'b0;
         running_ff <= '0;
         for (int i = 0; i < NS; i++) begin
            sem_count_ff[i] <= '0;
         end
         for (int t = 0; t < NT; t++) begin
            blk_valid_ff[t] <= 1'b0;
         end
      end else begin
         pc_ff      <= pc_in;
         strobe_ff  <= strobe_in;
         running_ff <= running_in;
         if (sem_we) begin
            sem_count_ff[sem_idx] <= sem_wdata;
         end
         if (blk_set) begin
            blk_valid_ff[running_ff] <= 1'b1;
         end
         if (blk_clr) begin
            blk_valid_ff[cand_ff] <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_func;
         sem_ff   <= req_sem_id;
         initv_ff <= req_init_value;
      end
      if (blk_set) begin
         blk_sem_ff[running_ff] <= sem_ff;
      end
      count_ff   <= count_in;
      cand_ff    <= cand_in;
      k_ff       <= k_in;
      status_ff  <= status_in;
      cblk_ff    <= cblk_in;
      woken_ff   <= woken_in;
      wthread_ff <= wthread_in;
   end

   // Working registers hold their values through the strobe cycle.
   assign rsp_strobe         = strobe_ff;
   assign rsp_running_thread = rrss_pkg::THREAD_W'(running_ff);
   assign rsp_caller_blocked = cblk_ff;
   assign rsp_woken_valid    = woken_ff;
   assign rsp_woken_thread   = rrss_pkg::THREAD_W'(wthread_ff);
   assign rsp_count_after    = count_ff;
   assign rsp_status         = status_ff;

   // Assertions.
   a_strobe_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(pc_ff) == rrss_pkg::STEP_FINISH)
      else $error("result strobe without a finish step");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("sequencer busy during result strobe");

   a_woken_only_signal: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_woken_valid |-> func_ff == rrss_pkg::FN_SIGNAL)
      else $error("thread woken by a request other than signal");

   a_block_negative: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_caller_blocked |-> rsp_count_after < 0)
      else $error("caller blocked with a nonnegative count");

   a_tick_runs_free: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && func_ff == rrss_pkg::FN_TICK && rsp_status == rrss_pkg::ST_OK
      |-> !blk_valid_ff[running_ff])
      else $error("tick selected a blocked thread");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the round-robin scheduler with blocking semaphores
// Drives scheduling requests through the start/busy handshake with random
// gaps, predicts each result from a local copy of the counts, the blocking
// records and the running thread, and checks every result strobe in order.
// ----------------------------------------------------------------------------
module tb;

   localparam int RESET_CYCLES = 8;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 16;

   localparam int NUM_THREADS = rrss_pkg::NUM_THREADS;
   localparam int NUM_SEMS    = rrss_pkg::NUM_SEMS;
   localparam int FUNC_W      = rrss_pkg::FUNC_W;
   localparam int SEM_ID_W    = rrss_pkg::SEM_ID_W;
   localparam int COUNT_W     = rrss_pkg::COUNT_W;
   localparam int THREAD_W    = rrss_pkg::THREAD_W;
   localparam int STATUS_W    = rrss_pkg::STATUS_W;

   typedef struct {
      logic [THREAD_W-1:0]        running;
      logic                       blocked;
      logic                       woken_valid;
      logic [THREAD_W-1:0]        woken;
      logic signed [COUNT_W-1:0]  count;
      logic [STATUS_W-1:0]        status;
   } sched_result_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic [FUNC_W-1:0]          req_func = '0;
   logic [SEM_ID_W-1:0]        req_sem_id = '0;
   logic signed [COUNT_W-1:0]  req_init_value = '0;
   logic                       rsp_strobe;
   logic [THREAD_W-1:0]        rsp_running_thread;
   logic                       rsp_caller_blocked;
   logic                       rsp_woken_valid;
   logic [THREAD_W-1:0]        rsp_woken_thread;
   logic signed [COUNT_W-1:0]  rsp_count_after;
   logic [STATUS_W-1:0]        rsp_status;

   // Scheduler state as the testbench expects it to be.
   logic signed [COUNT_W-1:0]  sem_cnt [NUM_SEMS];
   logic [3:0]                 waits_on [NUM_THREADS];
   logic [THREAD_W-1:0]        cur_thread;

   sched_result_type           pending_results [$];
   int                         errors = 0;
   int                         stall_cycles = 0;
   int                         calm_left = 0;

   round_robin_scheduler_semaphores dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_func           (req_func),
      .req_sem_id         (req_sem_id),
      .req_init_value     (req_init_value),
      .rsp_strobe         (rsp_strobe),
      .rsp_running_thread (rsp_running_thread),
      .rsp_caller_blocked (rsp_caller_blocked),
      .rsp_woken_valid    (rsp_woken_valid),
      .rsp_woken_thread   (rsp_woken_thread),
      .rsp_count_after    (rsp_count_after),
      .rsp_status         (rsp_status)
   );

   always #10 clock = ~clock;

   // Moves to the next thread that is not blocked; the running one is tried last.
   function automatic bit next_ready_thread();
      int t;
      for (int k = 1; k <= NUM_THREADS; k++) begin
         t = (int'(cur_thread) + k) % NUM_THREADS;
         if (waits_on[t] == 4'd0) begin
            cur_thread = THREAD_W'(t);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic sched_result_type schedule_op(input logic [FUNC_W-1:0] f,
                                                    input logic [SEM_ID_W-1:0] s,
                                                    input logic signed [COUNT_W-1:0] v);
      sched_result_type r;
      int               c;
      int               t;
      logic [3:0]       tag;
      r.running     = '0;
      r.blocked     = 1'b0;
      r.woken_valid = 1'b0;
      r.woken       = '0;
      r.count       = '0;
      r.status      = rrss_pkg::ST_OK;
      tag = 4'(s) + 4'd1;
      if (f == rrss_pkg::FN_TICK) begin
         if (!next_ready_thread()) r.status = rrss_pkg::ST_ALL_BLOCKED;
      end else if (int'(s) < NUM_SEMS) begin
         c = sem_cnt[s];
         case (f)
            rrss_pkg::FN_INIT: begin
               sem_cnt[s] = v;
            end
            rrss_pkg::FN_WAIT: begin
               if (c == -128) r.status = rrss_pkg::ST_SATURATED;
               else c = c - 1;
               sem_cnt[s] = COUNT_W'(c);
               if (c < 0) begin
                  waits_on[cur_thread] = tag;
                  r.blocked = 1'b1;
                  if (!next_ready_thread()) r.status = rrss_pkg::ST_ALL_BLOCKED;
               end
            end
            default: begin
               if (c == 127) r.status = rrss_pkg::ST_SATURATED;
               else c = c + 1;
               sem_cnt[s] = COUNT_W'(c);
               if (c <= 0) begin
                  for (int k = 1; k <= NUM_THREADS; k++) begin
                     t = (int'(cur_thread) + k) % NUM_THREADS;
                     if (waits_on[t] == tag) begin
                        waits_on[t] = 4'd0;
                        r.woken_valid = 1'b1;
                        r.woken = THREAD_W'(t);
                        break;
                     end
                  end
                  if (!r.woken_valid) r.status = rrss_pkg::ST_NO_WAITER;
               end
            end
         endcase
         r.count = sem_cnt[s];
      end
      r.running = cur_thread;
      return r;
   endfunction

   // Mostly short gaps, a few long ones, and now and then a run with none.
   function automatic int pick_gap();
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         calm_left = $urandom_range(10, 40);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_request(input logic [FUNC_W-1:0] f, input logic [SEM_ID_W-1:0] s,
                               input logic signed [COUNT_W-1:0] v);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_func       <= f;
      req_sem_id     <= s;
      req_init_value <= v;
      do @(posedge clock); while (busy);
      pending_results.push_back(schedule_op(f, s, v));
   endtask

   function automatic logic signed [COUNT_W-1:0] random_count();
      if ($urandom_range(0, 9) < 7) return COUNT_W'(int'($urandom_range(0, 5)) - 2);
      return COUNT_W'($urandom);
   endfunction

   task automatic random_request(input int sem_span);
      int                 r;
      logic [FUNC_W-1:0]  f;
      r = $urandom_range(0, 99);
      if (r < 25) f = rrss_pkg::FN_TICK;
      else if (r < 55) f = rrss_pkg::FN_WAIT;
      else if (r < 85) f = rrss_pkg::FN_SIGNAL;
      else f = rrss_pkg::FN_INIT;
      send_request(f, SEM_ID_W'($urandom_range(0, sem_span - 1)), random_count());
   endtask

   task automatic test_directed();
      send_request(rrss_pkg::FN_TICK,   3'd0, 8'sd0);
      send_request(rrss_pkg::FN_INIT,   3'd0, 8'sd127);
      send_request(rrss_pkg::FN_SIGNAL, 3'd0, 8'sd0);       // count stuck at the top
      send_request(rrss_pkg::FN_INIT,   3'd1, -8'sd128);
      send_request(rrss_pkg::FN_WAIT,   3'd1, 8'sd0);       // stuck at the bottom, still blocks
      send_request(rrss_pkg::FN_INIT,   3'd2, 8'sd0);
      send_request(rrss_pkg::FN_WAIT,   3'd2, 8'sd0);
      send_request(rrss_pkg::FN_WAIT,   3'd2, 8'sd0);       // last free thread blocks
      send_request(rrss_pkg::FN_TICK,   3'd7, 8'sd0);
      send_request(rrss_pkg::FN_INIT,   3'd3, 8'sd0);
      send_request(rrss_pkg::FN_WAIT,   3'd3, 8'sd0);       // a blocked thread waits again
      send_request(rrss_pkg::FN_SIGNAL, 3'd2, 8'sd0);
      send_request(rrss_pkg::FN_SIGNAL, 3'd2, 8'sd0);       // its waiter moved away
      send_request(rrss_pkg::FN_SIGNAL, 3'd1, 8'sd0);
      send_request(rrss_pkg::FN_SIGNAL, 3'd3, 8'sd0);
      send_request(rrss_pkg::FN_SIGNAL, 3'd5, 8'sd0);
      send_request(rrss_pkg::FN_TICK,   3'd0, 8'sd0);
      send_request(rrss_pkg::FN_TICK,   3'd0, 8'sd0);
      send_request(rrss_pkg::FN_TICK,   3'd0, 8'sd0);
      send_request(rrss_pkg::FN_INIT,   3'd7, -8'sd1);
      send_request(rrss_pkg::FN_SIGNAL, 3'd7, 8'sd0);
      send_request(rrss_pkg::FN_INIT,   3'd4, 8'sh55);
      send_request(rrss_pkg::FN_INIT,   3'd6, -8'sh56);
      send_request(rrss_pkg::FN_WAIT,   3'd4, 8'sd0);
      send_request(rrss_pkg::FN_WAIT,   3'd6, 8'sh7f);
   endtask

   // Random operations, mostly on a few semaphores so that threads contend.
   task automatic test_random_mix();
      repeat (650) begin
         if ($urandom_range(0, 3) != 0) random_request(3);
         else random_request(NUM_SEMS);
      end
   endtask

   task automatic test_saturation();
      logic [SEM_ID_W-1:0] s;
      int                  r;
      repeat (50) begin
         s = SEM_ID_W'($urandom_range(0, NUM_SEMS - 1));
         r = $urandom_range(0, 4);
         case (r)
            0:       send_request(rrss_pkg::FN_INIT, s, -8'sd128);
            1:       send_request(rrss_pkg::FN_INIT, s, -8'sd127);
            2:       send_request(rrss_pkg::FN_INIT, s, 8'sd127);
            3:       send_request(rrss_pkg::FN_INIT, s, 8'sd126);
            default: send_request(rrss_pkg::FN_INIT, s, COUNT_W'($urandom));
         endcase
         repeat (3) begin
            if ($urandom_range(0, 1) != 0) begin
               send_request(rrss_pkg::FN_WAIT, s, COUNT_W'($urandom));
            end else begin
               send_request(rrss_pkg::FN_SIGNAL, s, COUNT_W'($urandom));
            end
         end
      end
   endtask

   // One wait per thread on one semaphore drives toward all blocked; then signals, ticks and random requests dig out.
   task automatic test_all_blocked();
      logic [SEM_ID_W-1:0] s;
      int                  r;
      repeat (35) begin
         s = SEM_ID_W'($urandom_range(0, NUM_SEMS - 1));
         send_request(rrss_pkg::FN_INIT, s, 8'sd0);
         repeat (NUM_THREADS) send_request(rrss_pkg::FN_WAIT, s, random_count());
         repeat (3) begin
            r = $urandom_range(0, 9);
            if (r < 6) begin
               send_request(rrss_pkg::FN_SIGNAL, s, random_count());
            end else if (r < 8) begin
               send_request(rrss_pkg::FN_TICK, SEM_ID_W'($urandom), random_count());
            end else begin
               random_request(NUM_SEMS);
            end
         end
      end
   endtask

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : result_check
      sched_result_type e;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            $display("%0t ns: result strobe with no request pending", $time);
            errors++;
         end else begin
            e = pending_results.pop_front();
            check_field("running_thread", e.running,     rsp_running_thread);
            check_field("caller_blocked", e.blocked,     rsp_caller_blocked);
            check_field("woken_valid",    e.woken_valid, rsp_woken_valid);
            check_field("woken_thread",   e.woken,       rsp_woken_thread);
            check_field("count_after",    e.count,       rsp_count_after);
            check_field("status",         e.status,      rsp_status);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("%0t ns: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      foreach (sem_cnt[i]) sem_cnt[i] = '0;
      foreach (waits_on[i]) waits_on[i] = 4'd0;
      cur_thread = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_mix();
      test_saturation();
      test_all_blocked();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
